[hw/rtl/assert_macros.svh]
// assertion helpers, empty when synthesizing
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_IMPLIES(lbl, clk, rst_n, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);
`define ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define ASSERT_IMPLIES(lbl, clk, rst_n, pre, post, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg)
`endif

`endif

[hw/rtl/hcbd_pkg.sv]
`timescale 1ns / 1ps
package hcbd_pkg;

  localparam int unsigned SizeBitsDef  = 32;
  localparam int unsigned CountBitsDef = 16;
  localparam int unsigned EncLen       = 26;
  localparam logic [15:0] MaxBodyRst   = 16'hFFFF;

  localparam logic [7:0] ChCr = 8'd13;
  localparam logic [7:0] ChLf = 8'd10;
  localparam logic [7:0] ChT  = "t";

  localparam logic [2:0] StIdentity = 3'd0;
  localparam logic [2:0] StZeroChunk = 3'd1;
  localparam logic [2:0] StBadSize  = 3'd2;
  localparam logic [2:0] StLenCap   = 3'd3;
  localparam logic [2:0] StNoHdrEnd = 3'd4;
  localparam logic [2:0] StCutShort = 3'd5;

  typedef enum logic [6:0] {
    PhHeader  = 7'b0000001,
    PhIdent   = 7'b0000010,
    PhSize    = 7'b0000100,
    PhLeadGap = 7'b0001000,
    PhData    = 7'b0010000,
    PhTrail   = 7'b0100000,
    PhStop    = 7'b1000000
  } phase_e;

  typedef struct packed {
    logic [2:0] end_status;
    logic       body_last;
    logic       byte_valid;
    logic [7:0] body_byte;
  } result_t;

  function automatic logic [7:0] to_lower(input logic [7:0] b);
    to_lower = (b >= 8'd65 && b <= 8'd90) ? b + 8'd32 : b;
  endfunction

  function automatic logic is_crlf(input logic [7:0] b);
    is_crlf = (b == ChCr) || (b == ChLf);
  endfunction

  function automatic logic is_space(input logic [7:0] b);
    is_space = (b == 8'd32) || (b >= 8'd9 && b <= 8'd13);
  endfunction

  // {digit found, value}
  function automatic logic [4:0] hex_value(input logic [7:0] b);
    logic [7:0] v;
    v = 8'd0;
    hex_value = 5'd0;
    if (b >= 8'd48 && b <= 8'd57) begin
      v = b - 8'd48;
      hex_value = {1'b1, v[3:0]};
    end else if (b >= 8'd97 && b <= 8'd102) begin
      v = b - 8'd87;
      hex_value = {1'b1, v[3:0]};
    end else if (b >= 8'd65 && b <= 8'd70) begin
      v = b - 8'd55;
      hex_value = {1'b1, v[3:0]};
    end
  endfunction

  function automatic logic [7:0] sep_char(input logic [1:0] idx);
    sep_char = idx[0] ? ChLf : ChCr;
  endfunction

  // "transfer-encoding: chunked", lower case
  function automatic logic [7:0] enc_char(input logic [4:0] idx);
    unique case (idx)
      5'd0:  enc_char = "t";
      5'd1:  enc_char = "r";
      5'd2:  enc_char = "a";
      5'd3:  enc_char = "n";
      5'd4:  enc_char = "s";
      5'd5:  enc_char = "f";
      5'd6:  enc_char = "e";
      5'd7:  enc_char = "r";
      5'd8:  enc_char = "-";
      5'd9:  enc_char = "e";
      5'd10: enc_char = "n";
      5'd11: enc_char = "c";
      5'd12: enc_char = "o";
      5'd13: enc_char = "d";
      5'd14: enc_char = "i";
      5'd15: enc_char = "n";
      5'd16: enc_char = "g";
      5'd17: enc_char = ":";
      5'd18: enc_char = " ";
      5'd19: enc_char = "c";
      5'd20: enc_char = "h";
      5'd21: enc_char = "u";
      5'd22: enc_char = "n";
      5'd23: enc_char = "k";
      5'd24: enc_char = "e";
      5'd25: enc_char = "d";
      default: enc_char = "t";
    endcase
  endfunction

endpackage

[hw/rtl/http_chunked_body_decoder_top.sv]
`timescale 1ns / 1ps
// http chunked body decoder
// s_axis carries the raw response, one byte per transaction, tlast on the final byte.
// m_axis carries decoded body bytes; a transaction is sent for every emitted body byte
// and for the final response byte (tlast), which also carries the end status in tuser.
// cfg_we_i / cfg_wdata_i load the body length cap; write it only while the block is idle.
// a byte taken on s_axis is held in the input register; its result is registered in the
// result register and shown on m_axis.
// throughput: one byte per cycle unless m_axis stalls, set by the single decode stage
// between the input and result registers; all parsing state updates in that one stage.
// when the receiver stalls with a result held, one more byte is taken into the input
// register, then s_axis_tready_o drops until the result is taken.
// every byte waits in the input register until the result register is free, also a
// byte that produces no result.
// reset clears all parsing state and the valid flags of both registers, and sets the cap to 65535.
// after the final byte of a response the parsing state returns to its reset values,
// the cap keeps its value.
`include "assert_macros.svh"

module http_chunked_body_decoder_top #(
  parameter int unsigned SIZE_BITS  = hcbd_pkg::SizeBitsDef,
  parameter int unsigned COUNT_BITS = hcbd_pkg::CountBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // data_byte
  input  logic        s_axis_tlast_i,   // end_of_response
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,   // body_byte
  output logic [3:0]  m_axis_tuser_o,   // end_status[2:0], byte_valid
  output logic        m_axis_tlast_o    // body_last
);

  localparam int unsigned CapW = (COUNT_BITS > 16) ? COUNT_BITS : 16;

  logic [15:0]           max_len_q;
  logic                  in_valid_q;
  logic [7:0]            in_byte_q;
  logic                  in_last_q;
  logic                  out_valid_q;
  hcbd_pkg::result_t     out_q, res_d;
  logic                  advance, produce;

  hcbd_pkg::phase_e      phase_q, phase_d;
  logic [1:0]            sep_q, sep_d;
  logic [4:0]            enc_q, enc_d;
  logic                  chunked_q, chunked_d;
  logic [SIZE_BITS-1:0]  acc_q, acc_d;
  logic [3:0]            digits_q, digits_d;
  logic [SIZE_BITS-1:0]  remain_q, remain_d;
  logic [COUNT_BITS-1:0] count_q, count_d;
  logic [2:0]            stop_q, stop_d;

  logic [CapW-1:0]       cap;
  logic [CapW-1:0]       cfg_ext;
  logic [CapW-1:0]       cnt_max;
  logic                  cap_hit;
  logic [7:0]            b;
  logic [7:0]            lb;
  logic [4:0]            hv;
  logic                  do_size, do_emit, in_chunk;
  logic                  emit_ok;
  logic [2:0]            status;

  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;

  assign cfg_ext = CapW'(max_len_q);
  assign cnt_max = CapW'({COUNT_BITS{1'b1}});
  assign cap     = (cfg_ext < cnt_max) ? cfg_ext : cnt_max;
  assign cap_hit = CapW'(count_q) >= cap;
  assign b       = in_byte_q;
  assign lb      = hcbd_pkg::to_lower(in_byte_q);
  assign hv      = hcbd_pkg::hex_value(in_byte_q);

  always_comb begin
    phase_d   = phase_q;
    sep_d     = sep_q;
    enc_d     = enc_q;
    chunked_d = chunked_q;
    acc_d     = acc_q;
    digits_d  = digits_q;
    remain_d  = remain_q;
    count_d   = count_q;
    stop_d    = stop_q;
    do_size   = 1'b0;
    do_emit   = 1'b0;
    in_chunk  = 1'b0;
    emit_ok   = 1'b0;
    status    = hcbd_pkg::StIdentity;

    unique case (phase_q)
      hcbd_pkg::PhHeader: begin
        if (lb == hcbd_pkg::enc_char(enc_q)) begin
          if (enc_q == 5'(hcbd_pkg::EncLen - 1)) begin
            chunked_d = 1'b1;
            enc_d     = 5'd0;
          end else begin
            enc_d = enc_q + 5'd1;
          end
        end else begin
          enc_d = (lb == hcbd_pkg::ChT) ? 5'd1 : 5'd0;
        end
        if (b == hcbd_pkg::sep_char(sep_q)) begin
          if (sep_q == 2'd3) begin
            sep_d   = 2'd0;
            enc_d   = 5'd0;
            phase_d = chunked_d ? hcbd_pkg::PhSize : hcbd_pkg::PhIdent;
          end else begin
            sep_d = sep_q + 2'd1;
          end
        end else begin
          sep_d = (b == hcbd_pkg::ChCr) ? 2'd1 : 2'd0;
        end
      end
      hcbd_pkg::PhIdent: do_emit = 1'b1;
      hcbd_pkg::PhSize: do_size = 1'b1;
      hcbd_pkg::PhLeadGap: begin
        if (!hcbd_pkg::is_crlf(b)) begin
          phase_d  = hcbd_pkg::PhData;
          do_emit  = 1'b1;
          in_chunk = 1'b1;
        end
      end
      hcbd_pkg::PhData: begin
        do_emit  = 1'b1;
        in_chunk = 1'b1;
      end
      hcbd_pkg::PhTrail: begin
        if (!hcbd_pkg::is_crlf(b)) begin
          phase_d = hcbd_pkg::PhSize;
          do_size = 1'b1;
        end
      end
      hcbd_pkg::PhStop: ;
      default: ;
    endcase

    if (do_size) begin
      if (hv[4]) begin
        if (acc_q[SIZE_BITS-1 -: 4] != 4'd0) begin
          acc_d = '1;
        end else begin
          acc_d = {acc_q[SIZE_BITS-5:0], hv[3:0]};
        end
        if (digits_q != 4'd15) digits_d = digits_q + 4'd1;
      end else if (digits_q == 4'd0) begin
        if (!hcbd_pkg::is_space(b)) begin
          phase_d = hcbd_pkg::PhStop;
          stop_d  = hcbd_pkg::StBadSize;
        end
      end else if (acc_q == '0) begin
        phase_d = hcbd_pkg::PhStop;
        stop_d  = hcbd_pkg::StZeroChunk;
      end else begin
        remain_d = acc_q;
        acc_d    = '0;
        digits_d = 4'd0;
        if (hcbd_pkg::is_crlf(b)) begin
          phase_d = hcbd_pkg::PhLeadGap;
        end else begin
          phase_d  = hcbd_pkg::PhData;
          do_emit  = 1'b1;
          in_chunk = 1'b1;
        end
      end
    end

    if (do_emit) begin
      if (cap_hit) begin
        phase_d = hcbd_pkg::PhStop;
        stop_d  = hcbd_pkg::StLenCap;
      end else begin
        emit_ok = 1'b1;
        count_d = count_q + COUNT_BITS'(1);
        if (in_chunk) begin
          remain_d = remain_d - SIZE_BITS'(1);
          if (remain_d == '0) phase_d = hcbd_pkg::PhTrail;
        end
      end
    end

    unique case (phase_d)
      hcbd_pkg::PhStop:   status = stop_d;
      hcbd_pkg::PhHeader: status = hcbd_pkg::StNoHdrEnd;
      hcbd_pkg::PhIdent:  status = hcbd_pkg::StIdentity;
      hcbd_pkg::PhSize: begin
        if (digits_d == 4'd0)  status = hcbd_pkg::StBadSize;
        else if (acc_d == '0)  status = hcbd_pkg::StZeroChunk;
        else                   status = hcbd_pkg::StCutShort;
      end
      hcbd_pkg::PhLeadGap, hcbd_pkg::PhData: status = hcbd_pkg::StCutShort;
      default: status = hcbd_pkg::StBadSize;
    endcase

    if (in_last_q) begin
      phase_d   = hcbd_pkg::PhHeader;
      sep_d     = 2'd0;
      enc_d     = 5'd0;
      chunked_d = 1'b0;
      acc_d     = '0;
      digits_d  = 4'd0;
      remain_d  = '0;
      count_d   = '0;
      stop_d    = hcbd_pkg::StIdentity;
    end

    produce         = emit_ok || in_last_q;
    res_d.body_byte  = emit_ok ? b : 8'd0;
    res_d.byte_valid = emit_ok;
    res_d.body_last  = in_last_q;
    res_d.end_status = in_last_q ? status : hcbd_pkg::StIdentity;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q   <= hcbd_pkg::MaxBodyRst;
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      phase_q     <= hcbd_pkg::PhHeader;
      sep_q       <= 2'd0;
      enc_q       <= 5'd0;
      chunked_q   <= 1'b0;
      acc_q       <= '0;
      digits_q    <= 4'd0;
      remain_q    <= '0;
      count_q     <= '0;
      stop_q      <= hcbd_pkg::StIdentity;
    end else begin
      if (cfg_we_i) max_len_q <= cfg_wdata_i;
      if (s_axis_tready_o) in_valid_q <= s_axis_tvalid_i;
      if (advance) begin
        out_valid_q <= produce;
        phase_q     <= phase_d;
        sep_q       <= sep_d;
        enc_q       <= enc_d;
        chunked_q   <= chunked_d;
        acc_q       <= acc_d;
        digits_q    <= digits_d;
        remain_q    <= remain_d;
        count_q     <= count_d;
        stop_q      <= stop_d;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_byte_q <= s_axis_tdata_i;
      in_last_q <= s_axis_tlast_i;
    end
    if (advance && produce) out_q <= res_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_q.body_byte;
  assign m_axis_tuser_o  = {out_q.end_status, out_q.byte_valid};
  assign m_axis_tlast_o  = out_q.body_last;

  `ASSERT_IMPLIES(a_result_has_cause, clk_i, rst_ni, m_axis_tvalid_o, m_axis_tuser_o[0] || m_axis_tlast_o, "result with neither byte nor last")
  `ASSERT_IMPLIES(a_status_only_last, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tlast_o, m_axis_tuser_o[3:1] == hcbd_pkg::StIdentity, "end status outside last")
  `ASSERT_NEXT(a_input_held, clk_i, rst_ni, in_valid_q && !advance, in_valid_q && $stable(in_byte_q), "stalled byte lost")

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps
module tb_top;

  localparam int ItemGoal  = 1750;
  localparam int IdleLimit = 2000;
  localparam logic [8*hcbd_pkg::EncLen-1:0] EncText = "transfer-encoding: chunked";
  localparam logic [15:0] RowCr = 16'(hcbd_pkg::ChCr);
  localparam logic [15:0] RowLf = 16'(hcbd_pkg::ChLf);

  typedef enum logic {RowByte, RowCfg} row_kind_e;

  typedef struct {
    row_kind_e         kind;
    logic [15:0]       value;
    logic              last;
    logic              typed;
    hcbd_pkg::result_t want;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [15:0] cfg_wdata_i = '0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i = '0;
  logic        s_axis_tlast_i = 1'b0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [7:0]  m_axis_tdata_o;
  logic [3:0]  m_axis_tuser_o;
  logic        m_axis_tlast_o;

  http_chunked_body_decoder_top uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tlast_i (s_axis_tlast_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // decoder state mirror
  hcbd_pkg::phase_e ph;
  logic [1:0]  sep_cnt;
  logic [4:0]  enc_cnt;
  logic        chunked;
  logic [31:0] size_acc;
  logic [3:0]  size_dig;
  logic [31:0] chunk_left;
  logic [15:0] emitted;
  logic [2:0]  stop_code;
  logic [15:0] body_cap;
  logic        emit_v;
  logic [7:0]  emit_b;

  hcbd_pkg::result_t body_q[$];
  logic [7:0]  resp_q[$];
  dir_row_t    dir_q[$];
  int          n_items = 0;
  int          errors = 0;
  int          idle_cycles = 0;
  bit          quiet = 1'b0;

  function automatic logic [7:0] ascii_lower(input logic [7:0] b);
    return (b >= "A" && b <= "Z") ? b + 8'd32 : b;
  endfunction

  function automatic logic crlf_byte(input logic [7:0] b);
    return b == hcbd_pkg::ChCr || b == hcbd_pkg::ChLf;
  endfunction

  function automatic logic white_byte(input logic [7:0] b);
    return b == " " || (b >= 8'd9 && b <= 8'd13);
  endfunction

  function automatic int hex_nibble(input logic [7:0] b);
    if (b >= "0" && b <= "9") return int'(b) - 48;
    if (b >= "a" && b <= "f") return int'(b) - 87;
    if (b >= "A" && b <= "F") return int'(b) - 55;
    return -1;
  endfunction

  task automatic parse_clear();
    ph = hcbd_pkg::PhHeader;
    sep_cnt = '0;
    enc_cnt = '0;
    chunked = 1'b0;
    size_acc = '0;
    size_dig = '0;
    chunk_left = '0;
    emitted = '0;
    stop_code = '0;
  endtask

  task automatic body_stop(input logic [2:0] why);
    ph = hcbd_pkg::PhStop;
    stop_code = why;
  endtask

  task automatic body_emit(input logic [7:0] b, output logic ok);
    if (emitted >= body_cap) begin
      body_stop(hcbd_pkg::StLenCap);
      ok = 1'b0;
    end else begin
      emitted = emitted + 16'd1;
      emit_v = 1'b1;
      emit_b = b;
      ok = 1'b1;
    end
  endtask

  task automatic chunk_byte(input logic [7:0] b);
    logic ok;
    body_emit(b, ok);
    if (ok) begin
      chunk_left = chunk_left - 32'd1;
      if (chunk_left == 0) ph = hcbd_pkg::PhTrail;
    end
  endtask

  task automatic size_byte(input logic [7:0] b);
    int v;
    v = hex_nibble(b);
    if (v >= 0) begin
      if (size_acc > 32'h0FFF_FFFF) size_acc = '1;
      else size_acc = {size_acc[27:0], v[3:0]};
      if (size_dig < 4'd15) size_dig = size_dig + 4'd1;
    end else if (size_dig == 0) begin
      if (!white_byte(b)) body_stop(hcbd_pkg::StBadSize);
    end else if (size_acc == 0) begin
      body_stop(hcbd_pkg::StZeroChunk);
    end else begin
      chunk_left = size_acc;
      size_acc = '0;
      size_dig = '0;
      if (crlf_byte(b)) begin
        ph = hcbd_pkg::PhLeadGap;
      end else begin
        ph = hcbd_pkg::PhData;
        chunk_byte(b);
      end
    end
  endtask

  task automatic header_byte(input logic [7:0] b);
    logic [7:0] lb;
    logic [7:0] sep_want;
    lb = ascii_lower(b);
    if (lb == EncText[8*(hcbd_pkg::EncLen-1-int'(enc_cnt)) +: 8]) begin
      enc_cnt = enc_cnt + 5'd1;
      if (enc_cnt >= hcbd_pkg::EncLen) begin
        chunked = 1'b1;
        enc_cnt = '0;
      end
    end else begin
      enc_cnt = (lb == hcbd_pkg::ChT) ? 5'd1 : 5'd0;
    end
    sep_want = sep_cnt[0] ? hcbd_pkg::ChLf : hcbd_pkg::ChCr;
    if (b == sep_want) begin
      if (sep_cnt == 2'd3) begin
        sep_cnt = '0;
        enc_cnt = '0;
        ph = chunked ? hcbd_pkg::PhSize : hcbd_pkg::PhIdent;
      end else begin
        sep_cnt = sep_cnt + 2'd1;
      end
    end else begin
      sep_cnt = (b == hcbd_pkg::ChCr) ? 2'd1 : 2'd0;
    end
  endtask

  function automatic logic [2:0] end_code();
    case (ph)
      hcbd_pkg::PhStop:   return stop_code;
      hcbd_pkg::PhHeader: return hcbd_pkg::StNoHdrEnd;
      hcbd_pkg::PhIdent:  return hcbd_pkg::StIdentity;
      hcbd_pkg::PhSize: begin
        if (size_dig == 0) return hcbd_pkg::StBadSize;
        return (size_acc == 0) ? hcbd_pkg::StZeroChunk : hcbd_pkg::StCutShort;
      end
      hcbd_pkg::PhLeadGap, hcbd_pkg::PhData: return hcbd_pkg::StCutShort;
      default: return hcbd_pkg::StBadSize;
    endcase
  endfunction

  task automatic decode_byte(input logic [7:0] b, input logic l, output logic has,
                             output hcbd_pkg::result_t r);
    logic ok;
    logic [2:0] st;
    emit_v = 1'b0;
    emit_b = '0;
    st = '0;
    case (ph)
      hcbd_pkg::PhHeader:  header_byte(b);
      hcbd_pkg::PhIdent:   body_emit(b, ok);
      hcbd_pkg::PhSize:    size_byte(b);
      hcbd_pkg::PhLeadGap: begin
        if (!crlf_byte(b)) begin
          ph = hcbd_pkg::PhData;
          chunk_byte(b);
        end
      end
      hcbd_pkg::PhData:    chunk_byte(b);
      hcbd_pkg::PhTrail: begin
        if (!crlf_byte(b)) begin
          ph = hcbd_pkg::PhSize;
          size_byte(b);
        end
      end
      default: ;
    endcase
    if (l) begin
      st = end_code();
      parse_clear();
    end
    has = emit_v || l;
    r.body_byte = emit_v ? emit_b : 8'd0;
    r.byte_valid = emit_v;
    r.body_last = l;
    r.end_status = st;
  endtask

  task automatic send_item(input logic [7:0] b, input logic l, input logic typed,
                           input hcbd_pkg::result_t want);
    int gap;
    logic has;
    hcbd_pkg::result_t r;
    gap = 0;
    if (!quiet && $urandom_range(0, 3) == 0)
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= b;
    s_axis_tlast_i <= l;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    decode_byte(b, l, has, r);
    n_items++;
    if (typed) body_q.push_back(want);
    else if (has) body_q.push_back(r);
  endtask

  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (body_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_cap(input logic [15:0] v);
    drain();
    repeat (4) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    body_cap = v;
  endtask

  task automatic add_dir(input row_kind_e k, input logic [15:0] v, input logic l,
                         input logic t, input logic vld, input logic [2:0] st);
    dir_row_t row;
    row.kind = k;
    row.value = v;
    row.last = l;
    row.typed = t;
    row.want.body_byte = vld ? v[7:0] : 8'd0;
    row.want.byte_valid = vld;
    row.want.body_last = l;
    row.want.end_status = st;
    dir_q.push_back(row);
  endtask

  task automatic add_text(input string s, input logic mix);
    logic [7:0] c;
    for (int i = 0; i < s.len(); i++) begin
      c = s[i];
      if (mix && c >= "a" && c <= "z" && $urandom_range(0, 1) == 1) c = c - 8'd32;
      resp_q.push_back(c);
    end
  endtask

  task automatic add_crlf();
    resp_q.push_back(hcbd_pkg::ChCr);
    resp_q.push_back(hcbd_pkg::ChLf);
  endtask

  task automatic add_hex(input logic [31:0] v, input int width);
    int n;
    int k;
    logic [3:0] nib;
    n = 1;
    for (k = 1; k < 8; k++) if (v[4*k +: 4] != 0) n = k + 1;
    if (width > n) n = width;
    for (k = n - 1; k >= 0; k--) begin
      nib = (k < 8) ? v[4*k +: 4] : 4'd0;
      if (nib < 4'd10) resp_q.push_back("0" + nib);
      else resp_q.push_back((($urandom_range(0, 1) == 1) ? "a" : "A") + nib - 8'd10);
    end
  endtask

  task automatic build_response();
    int kind;
    int sz;
    int pick;
    int cut;
    resp_q.delete();
    kind = $urandom_range(0, 99);
    if ($urandom_range(0, 2) == 0) begin
      add_text("host: h", 1'b1);
      add_crlf();
    end
    if (kind < 60) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) add_text("t", 1'b1);
      if (pick == 1) add_text("transfer-encoding: chunkex", 1'b1);
      else add_text("transfer-encoding: chunked", 1'b1);
      add_crlf();
      if ($urandom_range(0, 2) == 0) begin
        add_text("x: 1", 1'b0);
        add_crlf();
      end
      add_crlf();
      repeat ($urandom_range(0, 4)) begin
        if ($urandom_range(0, 5) == 0) resp_q.push_back($urandom_range(0, 1) ? 8'd9 : " ");
        sz = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 8);
        add_hex(sz, ($urandom_range(0, 11) == 0) ? 17 : $urandom_range(1, 2));
        pick = $urandom_range(0, 9);
        if (pick == 1) begin
          resp_q.push_back(hcbd_pkg::ChLf);
        end else if (pick == 2) begin
          add_crlf();
          add_crlf();
        end else if (pick != 0) begin
          add_crlf();
        end
        repeat (sz) resp_q.push_back(8'($urandom_range(0, 255)));
        pick = $urandom_range(0, 9);
        if (pick == 1) resp_q.push_back(hcbd_pkg::ChLf);
        else if (pick != 0) add_crlf();
      end
      pick = $urandom_range(0, 9);
      if (pick <= 5) begin
        add_text("0", 1'b0);
        add_crlf();
        add_crlf();
      end else if (pick == 6) begin
        add_text("0x1", 1'b0);
      end else if (pick == 7) begin
        add_text(($urandom_range(0, 1) == 1) ? "+5" : "g", 1'b0);
      end else if (pick == 8) begin
        add_text("fffffffff7", 1'b1);
        add_crlf();
        repeat (3) resp_q.push_back(8'($urandom_range(0, 255)));
      end
    end else if (kind < 85) begin
      add_text("content-type: x", 1'b1);
      add_crlf();
      add_crlf();
      repeat ($urandom_range(1, 30)) resp_q.push_back(8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(3, 24)) resp_q.push_back(8'($urandom_range(0, 255)));
      if ($urandom_range(0, 1) == 1) begin
        add_crlf();
        add_crlf();
        repeat ($urandom_range(0, 8)) resp_q.push_back(8'($urandom_range(0, 255)));
      end
    end
    if ($urandom_range(0, 9) == 0 && resp_q.size() > 2) begin
      cut = $urandom_range(1, resp_q.size() - 1);
      while (resp_q.size() > cut) void'(resp_q.pop_back());
    end
    if ($urandom_range(0, 5) == 0)
      repeat ($urandom_range(1, 6)) resp_q.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic field_check(input string name, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      errors++;
    end
  endtask

  // result side
  always @(posedge clk_i) begin
    hcbd_pkg::result_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (body_q.size() == 0) begin
        $display("%0t: unexpected transaction expected none actual tdata %0h tuser %0h tlast %0b",
                 $time, m_axis_tdata_o, m_axis_tuser_o, m_axis_tlast_o);
        errors++;
      end else begin
        want = body_q.pop_front();
        field_check("body_byte", want.body_byte, m_axis_tdata_o);
        field_check("byte_valid", {7'd0, want.byte_valid}, {7'd0, m_axis_tuser_o[0]});
        field_check("end_status", {5'd0, want.end_status}, {5'd0, m_axis_tuser_o[3:1]});
        field_check("body_last", {7'd0, want.body_last}, {7'd0, m_axis_tlast_o});
      end
    end
  end

  initial begin
    int mode;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      mode = $urandom_range(0, 19);
      if (mode < 12) begin
        m_axis_tready_i <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk_i);
      end else if (mode < 13) begin
        m_axis_tready_i <= 1'b1;
        repeat ($urandom_range(100, 200)) @(posedge clk_i);
      end else if (mode < 18) begin
        m_axis_tready_i <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk_i);
      end else begin
        m_axis_tready_i <= 1'b0;
        repeat ($urandom_range(10, 50)) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("%0t: watchdog expired with %0d results pending", $time, body_q.size());
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin
    int resp_num;
    int pick;
    hcbd_pkg::result_t none;
    none = '0;
    parse_clear();
    body_cap = hcbd_pkg::MaxBodyRst;

    add_dir(RowByte, RowCr, 1'b0, 1'b0, 1'b0, '0);
    add_dir(RowByte, RowLf, 1'b0, 1'b0, 1'b0, '0);
    add_dir(RowByte, RowCr, 1'b0, 1'b0, 1'b0, '0);
    add_dir(RowByte, RowLf, 1'b0, 1'b0, 1'b0, '0);
    add_dir(RowByte, 16'h00, 1'b0, 1'b1, 1'b1, '0);
    add_dir(RowByte, 16'hFF, 1'b0, 1'b1, 1'b1, '0);
    add_dir(RowByte, 16'h41, 1'b1, 1'b1, 1'b1, hcbd_pkg::StIdentity);
    add_dir(RowCfg, 16'h0000, 1'b0, 1'b0, 1'b0, '0);
    add_dir(RowByte, RowCr, 1'b0, 1'b0, 1'b0, '0);
    add_dir(RowByte, RowLf, 1'b0, 1'b0, 1'b0, '0);
    add_dir(RowByte, RowCr, 1'b0, 1'b0, 1'b0, '0);
    add_dir(RowByte, RowLf, 1'b0, 1'b0, 1'b0, '0);
    add_dir(RowByte, 16'("Q"), 1'b1, 1'b1, 1'b0, hcbd_pkg::StLenCap);
    add_dir(RowCfg, 16'h0001, 1'b0, 1'b0, 1'b0, '0);
    add_dir(RowByte, RowLf, 1'b0, 1'b0, 1'b0, '0);
    add_dir(RowByte, RowCr, 1'b0, 1'b0, 1'b0, '0);
    add_dir(RowByte, RowLf, 1'b0, 1'b0, 1'b0, '0);
    add_dir(RowByte, RowCr, 1'b0, 1'b0, 1'b0, '0);
    add_dir(RowByte, RowLf, 1'b0, 1'b0, 1'b0, '0);
    add_dir(RowByte, 16'h80, 1'b0, 1'b1, 1'b1, '0);
    add_dir(RowByte, 16'h7F, 1'b1, 1'b1, 1'b0, hcbd_pkg::StLenCap);
    add_dir(RowCfg, 16'hFFFF, 1'b0, 1'b0, 1'b0, '0);
    add_dir(RowByte, 16'("T"), 1'b1, 1'b1, 1'b0, hcbd_pkg::StNoHdrEnd);
    add_dir(RowByte, RowCr, 1'b0, 1'b0, 1'b0, '0);
    add_dir(RowByte, RowLf, 1'b0, 1'b0, 1'b0, '0);
    add_dir(RowByte, RowCr, 1'b0, 1'b0, 1'b0, '0);
    add_dir(RowByte, RowLf, 1'b1, 1'b1, 1'b0, hcbd_pkg::StIdentity);

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_q[i]) begin
      if (dir_q[i].kind == RowCfg) write_cap(dir_q[i].value);
      else send_item(dir_q[i].value[7:0], dir_q[i].last, dir_q[i].typed, dir_q[i].want);
    end

    resp_num = 0;
    while (n_items < ItemGoal) begin
      if ($urandom_range(0, 3) == 0) begin
        pick = $urandom_range(0, 5);
        case (pick)
          0: write_cap(16'h0000);
          1: write_cap(16'h0001);
          2: write_cap(16'hFFFF);
          5: write_cap(16'($urandom_range(0, 65535)));
          default: write_cap(16'($urandom_range(2, 40)));
        endcase
      end
      quiet = ($urandom_range(0, 4) == 0);
      build_response();
      foreach (resp_q[i]) begin
        if (resp_num == 2 && i == resp_q.size() / 2) drain();
        send_item(resp_q[i], i == resp_q.size() - 1, 1'b0, none);
      end
      resp_num++;
    end

    drain();
    repeat (20) @(posedge clk_i);
    if (body_q.size() != 0) begin
      $display("%0t: %0d results expected actual none", $time, body_q.size());
      errors++;
    end
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/hcbd_pkg.sv
hw/rtl/http_chunked_body_decoder_top.sv
tb/sv/tb_top.sv
